// ===== rtl/chrd_pkg.sv =====
package chrd_pkg;

   localparam int MAX_CODE_LEN = 24;
   localparam int LEN_W = 6;
   localparam int NUM_LEN = MAX_CODE_LEN + 1;
   localparam int LIDX_W = $clog2(NUM_LEN);
   localparam int CODE_W = MAX_CODE_LEN;
   localparam int FIRST_W = MAX_CODE_LEN + 1;
   localparam int CNT_W = 9;
   localparam logic [7:0] ESCAPE_SYMBOL = 8'hFF;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_LOAD = 2'd1;
   localparam logic [1:0] ACT_FINALIZE = 2'd2;
   localparam logic [1:0] ACT_PAYLOAD = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_TOO_LONG = 2'd1;
   localparam logic [1:0] ST_TRUNCATED = 2'd2;
   localparam logic [1:0] ST_BAD_LENGTH = 2'd3;

   localparam logic [1:0] PH_FREE = 2'd0;
   localparam logic [1:0] PH_RUN = 2'd1;
   localparam logic [1:0] PH_BYTE = 2'd2;

   typedef struct packed {
      logic       hit;
      logic [7:0] idx;
   } match_type;

   typedef struct packed {
      logic [7:0] value;
      logic [7:0] repeat_res;
      logic [1:0] status;
   } res_type;

endpackage

// ===== rtl/chrd_match.sv =====
module chrd_match (
   input  logic [chrd_pkg::CODE_W-1:0]  code,
   input  logic [chrd_pkg::FIRST_W-1:0] base,
   input  logic [chrd_pkg::CNT_W-1:0]   count,
   input  logic [chrd_pkg::CNT_W-1:0]   offset,
   output chrd_pkg::match_type          result
);

   logic [chrd_pkg::FIRST_W-1:0] code_ext;
   logic [chrd_pkg::FIRST_W-1:0] diff;
   logic [chrd_pkg::CNT_W-1:0]   sum;

   assign code_ext = {1'b0, code};
   assign diff = code_ext - base;
   assign sum = offset + diff[chrd_pkg::CNT_W-1:0];

   // The code belongs to this length when it lies in [base, base + count).
   assign result.hit = (code_ext >= base) &&
                       (diff < chrd_pkg::FIRST_W'(count));
   assign result.idx = sum[7:0];

endmodule

// ===== rtl/canonical_huffman_rle_decoder.sv =====
// Canonical Huffman decoder with run-length expansion over byte symbols.
// An item is taken when start is high while busy is low. req_action selects:
// clear the code-length table, load one (symbol, length) pair, finalize the
// canonical codes, or decode one payload byte of up to eight bits.
// Each result appears on the rsp_ ports for exactly one cycle with rsp_valid
// high; the receiver cannot stall the decoder.
// Clear and load keep busy low; a load with a length above 24 returns one
// result with status 3 in the following cycle.
// Finalize walks the 256-entry length memory twice, to count each length and
// to place the sorted symbols, and builds the table for lengths 1 to 24 between.
// A payload byte is decoded one bit per cycle, except that each decoded symbol
// adds an S_SYM step for the sorted-symbol memory read; S_END1 and S_END2 close
// the byte, and busy stays high until they are done.
// Results are held until the next result or the byte's end, so the final one
// of a stream can carry rsp_last; an end byte with no result gives one marker.
// Reset clears the length table, the code tables and the decoding state;
// no clearing pass is needed, since a valid bit guards each length entry.
module canonical_huffman_rle_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_action,
   input  logic [7:0] req_symbol,
   input  logic [5:0] req_code_length,
   input  logic [7:0] req_payload_byte,
   input  logic [3:0] req_payload_bits,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   output logic [7:0] rsp_value,
   output logic [7:0] rsp_repeat_res,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   typedef enum logic [3:0] {
      S_IDLE, S_CNT_RD, S_CNT_USE, S_FIRST, S_SORT_RD, S_SORT_USE,
      S_BIT, S_SYM, S_END1, S_END2
   } state_type;

   localparam int LW = chrd_pkg::LIDX_W;
   localparam int NL = chrd_pkg::NUM_LEN;

   state_type state_ff;

   // length memory with per-entry valid bits
   logic [chrd_pkg::LEN_W-1:0] len_mem [256];
   logic [255:0]               len_vld_ff;
   logic [chrd_pkg::LEN_W-1:0] len_q_ff;
   logic                       len_q_vld_ff;
   logic                       len_we;
   logic [chrd_pkg::LEN_W-1:0] len_wdata;

   // sorted symbols
   logic [7:0] sort_mem [256];
   logic [7:0] sort_q_ff;
   logic       sort_we;
   logic [7:0] sort_waddr;

   logic [chrd_pkg::CNT_W-1:0]   cnt_ff   [NL];
   logic [chrd_pkg::FIRST_W-1:0] first_ff [NL];
   logic [chrd_pkg::CNT_W-1:0]   off_ff   [NL];
   logic [chrd_pkg::CNT_W-1:0]   nxt_ff   [NL];

   logic [7:0]    sym_cnt_ff;
   logic [LW-1:0] len_idx_ff;

   logic [chrd_pkg::CODE_W-1:0] pcode_ff;
   logic [LW-1:0]               plen_ff;
   logic [1:0]                  phase_ff;
   logic [7:0]                  held_run_ff;
   logic [7:0]                  shift_ff;
   logic [3:0]                  bits_left_ff;
   logic                        eos_ff;

   chrd_pkg::res_type pend_ff;
   logic              pend_vld_ff;

   // bit step
   logic                        bit_in;
   logic [chrd_pkg::CODE_W-1:0] code_in;
   logic [LW-1:0]               len_in;
   chrd_pkg::match_type         match;

   // finalize helpers
   logic [chrd_pkg::LEN_W-1:0] cur_len;
   logic                       cur_len_ok;
   logic [LW-1:0]              prev_idx;
   logic [chrd_pkg::FIRST_W:0] first_sum;
   logic [chrd_pkg::FIRST_W:0] first_dbl;
   logic [chrd_pkg::FIRST_W:0] first_cap;
   logic [chrd_pkg::FIRST_W:0] first_new;
   logic [chrd_pkg::CNT_W-1:0] off_new;

   // result push
   logic              push;
   chrd_pkg::res_type push_res;

   assign busy = (state_ff != S_IDLE);

   assign bit_in = shift_ff[7];
   assign code_in = {pcode_ff[chrd_pkg::CODE_W-2:0], bit_in};
   assign len_in = plen_ff + LW'(1);

   chrd_match u_match (
      .code   (code_in),
      .base   (first_ff[len_in]),
      .count  (cnt_ff[len_in]),
      .offset (off_ff[len_in]),
      .result (match)
   );

   assign cur_len = len_q_vld_ff ? len_q_ff : '0;
   assign cur_len_ok = (cur_len != '0) &&
                       (cur_len <= chrd_pkg::LEN_W'(chrd_pkg::MAX_CODE_LEN));
   assign prev_idx = len_idx_ff - LW'(1);
   assign first_sum = (chrd_pkg::FIRST_W+1)'(first_ff[prev_idx]) +
                      (chrd_pkg::FIRST_W+1)'(cnt_ff[prev_idx]);
   assign first_dbl = {first_sum[chrd_pkg::FIRST_W-1:0], 1'b0};
   assign first_cap = (chrd_pkg::FIRST_W+1)'(1) << len_idx_ff;
   assign first_new = (len_idx_ff == LW'(1)) ? '0 :
                      ((first_dbl > first_cap) ? first_cap : first_dbl);
   assign off_new = (len_idx_ff == LW'(1)) ? '0 : (off_ff[prev_idx] + cnt_ff[prev_idx]);

   assign len_we = (state_ff == S_IDLE) && start && (req_action == chrd_pkg::ACT_LOAD);
   assign len_wdata = (req_code_length > chrd_pkg::LEN_W'(chrd_pkg::MAX_CODE_LEN)) ?
                      '0 : req_code_length;

   assign sort_we = (state_ff == S_SORT_USE) && cur_len_ok;
   assign sort_waddr = nxt_ff[cur_len[LW-1:0]][7:0];

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[req_symbol] <= len_wdata;
      end
      len_q_ff <= len_mem[sym_cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (sort_we) begin
         sort_mem[sort_waddr] <= sym_cnt_ff;
      end
      sort_q_ff <= sort_mem[match.idx];
   end

   // Which result, if any, the current cycle produces.
   always_comb begin
      push = 1'b0;
      push_res = '0;
      unique case (state_ff)
         S_BIT: begin
            if (!match.hit && (len_in == LW'(chrd_pkg::MAX_CODE_LEN))) begin
               push = 1'b1;
               push_res.status = chrd_pkg::ST_TOO_LONG;
            end
         end
         S_SYM: begin
            if (phase_ff == chrd_pkg::PH_BYTE) begin
               push = 1'b1;
               push_res.value = sort_q_ff;
               push_res.repeat_res = held_run_ff;
            end else if ((phase_ff == chrd_pkg::PH_FREE) &&
                         (sort_q_ff != chrd_pkg::ESCAPE_SYMBOL)) begin
               push = 1'b1;
               push_res.value = sort_q_ff;
               push_res.repeat_res = 8'd1;
            end
         end
         S_END1: begin
            if (eos_ff && (phase_ff != chrd_pkg::PH_FREE)) begin
               push = 1'b1;
               push_res.status = chrd_pkg::ST_TRUNCATED;
            end
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_vld_ff <= '0;
         len_q_vld_ff <= 1'b0;
         for (int i = 0; i < NL; i++) begin
            cnt_ff[i] <= '0;
            first_ff[i] <= '0;
            off_ff[i] <= '0;
            nxt_ff[i] <= '0;
         end
         sym_cnt_ff <= '0;
         len_idx_ff <= '0;
         pcode_ff <= '0;
         plen_ff <= '0;
         phase_ff <= chrd_pkg::PH_FREE;
         held_run_ff <= '0;
         shift_ff <= '0;
         bits_left_ff <= '0;
         eos_ff <= 1'b0;
         pend_ff <= '0;
         pend_vld_ff <= 1'b0;
         rsp_valid <= 1'b0;
         rsp_value <= '0;
         rsp_repeat_res <= '0;
         rsp_status <= '0;
         rsp_last <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         rsp_last <= 1'b0;
         len_q_vld_ff <= len_vld_ff[sym_cnt_ff];

         // A new result pushes out the held one.
         if (push) begin
            if (pend_vld_ff) begin
               rsp_valid <= 1'b1;
               rsp_value <= pend_ff.value;
               rsp_repeat_res <= pend_ff.repeat_res;
               rsp_status <= pend_ff.status;
            end
            pend_ff <= push_res;
            pend_vld_ff <= 1'b1;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  unique case (req_action)
                     chrd_pkg::ACT_CLEAR: begin
                        len_vld_ff <= '0;
                        for (int i = 0; i < NL; i++) begin
                           cnt_ff[i] <= '0;
                           first_ff[i] <= '0;
                           off_ff[i] <= '0;
                        end
                        pcode_ff <= '0;
                        plen_ff <= '0;
                        phase_ff <= chrd_pkg::PH_FREE;
                        held_run_ff <= '0;
                     end
                     chrd_pkg::ACT_LOAD: begin
                        len_vld_ff[req_symbol] <= 1'b1;
                        if (req_code_length >
                            chrd_pkg::LEN_W'(chrd_pkg::MAX_CODE_LEN)) begin
                           rsp_valid <= 1'b1;
                           rsp_value <= '0;
                           rsp_repeat_res <= '0;
                           rsp_status <= chrd_pkg::ST_BAD_LENGTH;
                        end
                     end
                     chrd_pkg::ACT_FINALIZE: begin
                        for (int i = 0; i < NL; i++) begin
                           cnt_ff[i] <= '0;
                           first_ff[i] <= '0;
                           off_ff[i] <= '0;
                        end
                        sym_cnt_ff <= '0;
                        state_ff <= S_CNT_RD;
                     end
                     chrd_pkg::ACT_PAYLOAD: begin
                        shift_ff <= req_payload_byte;
                        eos_ff <= req_end_of_stream;
                        bits_left_ff <= (req_payload_bits > 4'd8) ? 4'd8 : req_payload_bits;
                        state_ff <= (req_payload_bits == 4'd0) ? S_END1 : S_BIT;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_CNT_RD: begin
               state_ff <= S_CNT_USE;
            end
            S_CNT_USE: begin
               if (cur_len_ok) begin
                  cnt_ff[cur_len[LW-1:0]] <= cnt_ff[cur_len[LW-1:0]] + chrd_pkg::CNT_W'(1);
               end
               if (sym_cnt_ff == 8'hFF) begin
                  sym_cnt_ff <= '0;
                  len_idx_ff <= LW'(1);
                  state_ff <= S_FIRST;
               end else begin
                  sym_cnt_ff <= sym_cnt_ff + 8'd1;
                  state_ff <= S_CNT_RD;
               end
            end
            S_FIRST: begin
               first_ff[len_idx_ff] <= first_new[chrd_pkg::FIRST_W-1:0];
               off_ff[len_idx_ff] <= off_new;
               nxt_ff[len_idx_ff] <= off_new;
               if (len_idx_ff == LW'(chrd_pkg::MAX_CODE_LEN)) begin
                  state_ff <= S_SORT_RD;
               end else begin
                  len_idx_ff <= len_idx_ff + LW'(1);
               end
            end
            S_SORT_RD: begin
               state_ff <= S_SORT_USE;
            end
            S_SORT_USE: begin
               // Symbols arrive in ascending order, so each length's slot
               // pointer places them in canonical order.
               if (cur_len_ok) begin
                  nxt_ff[cur_len[LW-1:0]] <= nxt_ff[cur_len[LW-1:0]] + chrd_pkg::CNT_W'(1);
               end
               if (sym_cnt_ff == 8'hFF) begin
                  sym_cnt_ff <= '0;
                  pcode_ff <= '0;
                  plen_ff <= '0;
                  phase_ff <= chrd_pkg::PH_FREE;
                  held_run_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  sym_cnt_ff <= sym_cnt_ff + 8'd1;
                  state_ff <= S_SORT_RD;
               end
            end
            S_BIT: begin
               shift_ff <= {shift_ff[6:0], 1'b0};
               bits_left_ff <= bits_left_ff - 4'd1;
               if (match.hit) begin
                  pcode_ff <= '0;
                  plen_ff <= '0;
                  state_ff <= S_SYM;
               end else if (len_in == LW'(chrd_pkg::MAX_CODE_LEN)) begin
                  pcode_ff <= '0;
                  plen_ff <= '0;
                  state_ff <= (bits_left_ff == 4'd1) ? S_END1 : S_BIT;
               end else begin
                  pcode_ff <= code_in;
                  plen_ff <= len_in;
                  state_ff <= (bits_left_ff == 4'd1) ? S_END1 : S_BIT;
               end
            end
            S_SYM: begin
               unique case (phase_ff)
                  chrd_pkg::PH_RUN: begin
                     held_run_ff <= sort_q_ff;
                     phase_ff <= chrd_pkg::PH_BYTE;
                  end
                  chrd_pkg::PH_BYTE: begin
                     phase_ff <= chrd_pkg::PH_FREE;
                  end
                  default: begin
                     if (sort_q_ff == chrd_pkg::ESCAPE_SYMBOL) begin
                        phase_ff <= chrd_pkg::PH_RUN;
                     end
                  end
               endcase
               state_ff <= (bits_left_ff == 4'd0) ? S_END1 : S_BIT;
            end
            S_END1: begin
               state_ff <= S_END2;
            end
            S_END2: begin
               if (eos_ff) begin
                  // The held result, or a marker when this byte gave none,
                  // closes the stream.
                  rsp_valid <= 1'b1;
                  rsp_last <= 1'b1;
                  rsp_value <= pend_vld_ff ? pend_ff.value : 8'd0;
                  rsp_repeat_res <= pend_vld_ff ? pend_ff.repeat_res : 8'd0;
                  rsp_status <= pend_vld_ff ? pend_ff.status : chrd_pkg::ST_OK;
                  pcode_ff <= '0;
                  plen_ff <= '0;
                  phase_ff <= chrd_pkg::PH_FREE;
                  held_run_ff <= '0;
               end else if (pend_vld_ff) begin
                  rsp_valid <= 1'b1;
                  rsp_value <= pend_ff.value;
                  rsp_repeat_res <= pend_ff.repeat_res;
                  rsp_status <= pend_ff.status;
               end
               pend_vld_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [7:0] value;
      logic [7:0] repeat_res;
      logic [1:0] status;
      logic       last;
   } decoded_type;

   typedef struct {
      logic [1:0]  action;
      logic [7:0]  symbol;
      logic [5:0]  code_length;
      logic [7:0]  payload_byte;
      logic [3:0]  payload_bits;
      logic        end_of_stream;
      bit          typed;
      decoded_type fixed;
   } beat_type;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic [1:0] req_action;
   logic [7:0] req_symbol;
   logic [5:0] req_code_length;
   logic [7:0] req_payload_byte;
   logic [3:0] req_payload_bits;
   logic       req_end_of_stream;
   logic       rsp_valid;
   logic [7:0] rsp_value;
   logic [7:0] rsp_repeat_res;
   logic [1:0] rsp_status;
   logic       rsp_last;

   canonical_huffman_rle_decoder u_dut (.*);

   // Decoder shadow state.
   logic [5:0]  code_len_mem [256];
   int          len_count [chrd_pkg::NUM_LEN];
   longint      first_code [chrd_pkg::NUM_LEN];
   int          len_offset [chrd_pkg::NUM_LEN];
   logic [7:0]  sym_by_rank [256];
   longint      part_code;
   int          part_len;
   logic [1:0]  trip_phase;
   logic [7:0]  held_run;

   decoded_type pending_q [$];
   int          mismatches = 0;
   int          beats_sent = 0;
   int          results_seen = 0;
   int          error_results = 0;
   int          streams = 0;
   int          tables = 0;
   int          quiet_cycles = 0;
   bit          idle_on = 1;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_decode_state();
      part_code = 0;
      part_len = 0;
      trip_phase = chrd_pkg::PH_FREE;
      held_run = 0;
   endfunction

   function automatic void clear_len_tables();
      for (int l = 0; l < chrd_pkg::NUM_LEN; l++) begin
         len_count[l] = 0;
         first_code[l] = 0;
         len_offset[l] = 0;
      end
   endfunction

   function automatic void build_canonical();
      int pos;
      longint f;
      pos = 0;
      clear_len_tables();
      for (int s = 0; s < 256; s++)
         if (code_len_mem[s] >= 1 && code_len_mem[s] <= chrd_pkg::MAX_CODE_LEN)
            len_count[code_len_mem[s]]++;
      for (int l = 1; l <= chrd_pkg::MAX_CODE_LEN; l++) begin
         f = 0;
         if (l > 1) begin
            f = (first_code[l-1] + len_count[l-1]) << 1;
            len_offset[l] = len_offset[l-1] + len_count[l-1];
         end
         if (f > (longint'(1) << l))
            f = longint'(1) << l;
         first_code[l] = f;
         for (int s = 0; s < 256; s++)
            if (code_len_mem[s] == l) begin
               sym_by_rank[pos & 255] = s[7:0];
               pos++;
            end
      end
   endfunction

   function automatic decoded_type mk_res(logic [7:0] v, logic [7:0] r, logic [1:0] st);
      decoded_type d;
      d.value = v;
      d.repeat_res = r;
      d.status = st;
      d.last = 0;
      return d;
   endfunction

   // Advances the shadow state by one accepted beat and returns its results.
   function automatic void decode_beat(beat_type b, ref decoded_type res [$]);
      int nb;
      logic [7:0] sym;
      longint base;
      res.delete();
      case (b.action)
         chrd_pkg::ACT_CLEAR: begin
            for (int s = 0; s < 256; s++)
               code_len_mem[s] = 0;
            clear_len_tables();
            clear_decode_state();
         end
         chrd_pkg::ACT_LOAD: begin
            if (b.code_length > chrd_pkg::MAX_CODE_LEN) begin
               code_len_mem[b.symbol] = 0;
               res.push_back(mk_res(0, 0, chrd_pkg::ST_BAD_LENGTH));
            end else begin
               code_len_mem[b.symbol] = b.code_length;
            end
         end
         chrd_pkg::ACT_FINALIZE: begin
            build_canonical();
            clear_decode_state();
         end
         default: begin
            nb = (b.payload_bits > 8) ? 8 : b.payload_bits;
            for (int i = 0; i < nb; i++) begin
               part_code = (part_code << 1) | b.payload_byte[7-i];
               part_len++;
               base = first_code[part_len];
               if (part_code >= base && part_code - base < len_count[part_len]) begin
                  sym = sym_by_rank[(len_offset[part_len] + (part_code - base)) & 255];
                  part_code = 0;
                  part_len = 0;
                  if (trip_phase == chrd_pkg::PH_RUN) begin
                     held_run = sym;
                     trip_phase = chrd_pkg::PH_BYTE;
                  end else if (trip_phase == chrd_pkg::PH_BYTE) begin
                     res.push_back(mk_res(sym, held_run, chrd_pkg::ST_OK));
                     trip_phase = chrd_pkg::PH_FREE;
                  end else if (sym == chrd_pkg::ESCAPE_SYMBOL) begin
                     trip_phase = chrd_pkg::PH_RUN;
                  end else begin
                     res.push_back(mk_res(sym, 1, chrd_pkg::ST_OK));
                  end
               end else if (part_len == chrd_pkg::MAX_CODE_LEN) begin
                  part_code = 0;
                  part_len = 0;
                  res.push_back(mk_res(0, 0, chrd_pkg::ST_TOO_LONG));
               end
            end
            if (b.end_of_stream) begin
               if (trip_phase != chrd_pkg::PH_FREE)
                  res.push_back(mk_res(0, 0, chrd_pkg::ST_TRUNCATED));
               if (res.size() == 0)
                  res.push_back(mk_res(0, 0, chrd_pkg::ST_OK));
               res[res.size()-1].last = 1;
               clear_decode_state();
            end
         end
      endcase
   endfunction

   // Start stays high after the accepting edge; the next call, or the caller
   // before it waits, drives it again in that same time step.
   task automatic send_beat(beat_type b);
      decoded_type res [$];
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start <= 1;
      req_action <= b.action;
      req_symbol <= b.symbol;
      req_code_length <= b.code_length;
      req_payload_byte <= b.payload_byte;
      req_payload_bits <= b.payload_bits;
      req_end_of_stream <= b.end_of_stream;
      do
         @(posedge clock);
      while (busy);
      decode_beat(b, res);
      if (b.typed)
         pending_q.push_back(b.fixed);
      else
         foreach (res[i])
            pending_q.push_back(res[i]);
      beats_sent++;
   endtask

   function automatic beat_type mk_beat(logic [1:0] act, logic [7:0] sym, logic [5:0] len,
                                        logic [7:0] pb, logic [3:0] nbits, logic eos);
      beat_type b;
      b.action = act;
      b.symbol = sym;
      b.code_length = len;
      b.payload_byte = pb;
      b.payload_bits = nbits;
      b.end_of_stream = eos;
      b.typed = 0;
      b.fixed = mk_res(0, 0, chrd_pkg::ST_OK);
      return b;
   endfunction

   function automatic beat_type mk_typed(beat_type b, decoded_type d);
      b.typed = 1;
      b.fixed = d;
      return b;
   endfunction

   function automatic beat_type rand_payload(logic eos);
      logic [3:0] nbits;
      nbits = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
      return mk_beat(chrd_pkg::ACT_PAYLOAD, 8'($urandom), 6'($urandom), 8'($urandom),
                     nbits, eos);
   endfunction

   // Loads a Kraft-complete (if gapped, incomplete) table; stray loads may mar it.
   task automatic load_table(bit skewed, bit gapped);
      int lens [$];
      bit taken [256];
      int want, idx, l, guard;
      int s;
      lens = '{1, 1};
      want = $urandom_range(2, 24);
      guard = 0;
      while (lens.size() < want && guard < 200) begin
         idx = skewed ? lens.size() - 1 : $urandom_range(0, lens.size() - 1);
         l = lens[idx];
         if (l < chrd_pkg::MAX_CODE_LEN) begin
            lens.delete(idx);
            lens.push_back(l + 1);
            lens.push_back(l + 1);
         end
         guard++;
      end
      if (gapped)
         lens.delete($urandom_range(0, lens.size() - 1));
      foreach (taken[i])
         taken[i] = 0;
      foreach (lens[i]) begin
         if (i == 0 && $urandom_range(0, 9) < 8)
            s = 255;
         else
            do s = $urandom_range(0, 255); while (taken[s]);
         taken[s] = 1;
         send_beat(mk_beat(chrd_pkg::ACT_LOAD, s[7:0], lens[i][5:0], 8'($urandom),
                           4'($urandom), 1'($urandom)));
         if ($urandom_range(0, 7) == 0)
            send_beat(mk_beat(chrd_pkg::ACT_LOAD, 8'($urandom), 6'($urandom), 8'($urandom),
                              4'($urandom), 0));
      end
      tables++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (rsp_status != chrd_pkg::ST_OK)
            error_results++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value=%h repeat=%h status=%0d last=%b",
                        rsp_value, rsp_repeat_res, rsp_status, rsp_last);
         end else begin
            if (rsp_value !== pending_q[0].value || rsp_repeat_res !== pending_q[0].repeat_res ||
                rsp_status !== pending_q[0].status || rsp_last !== pending_q[0].last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h/%h/%0d/%b got %h/%h/%0d/%b",
                           pending_q[0].value, pending_q[0].repeat_res, pending_q[0].status,
                           pending_q[0].last, rsp_value, rsp_repeat_res, rsp_status, rsp_last);
            end
            void'(pending_q.pop_front());
         end
      end
   end

   // Finalize walks the whole symbol store, so the limit sits well above it.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      beat_type dir [$];
      int nstream;
      reset = 1;
      start = 0;
      req_action = chrd_pkg::ACT_CLEAR;
      req_symbol = 0;
      req_code_length = 0;
      req_payload_byte = 0;
      req_payload_bits = 0;
      req_end_of_stream = 0;
      for (int s = 0; s < 256; s++) begin
         code_len_mem[s] = 0;
         sym_by_rank[s] = 0;
      end
      clear_len_tables();
      clear_decode_state();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Table: 0x41 -> 0, 0xFF -> 10, 0x00 -> 110; codes starting 111 never match.
      dir.push_back(mk_typed(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'hA5, 8, 1),
                             '{8'h00, 8'h00, chrd_pkg::ST_OK, 1'b1}));
      dir.push_back(mk_typed(mk_beat(chrd_pkg::ACT_LOAD, 8'h05, 6'd63, 0, 0, 0),
                             '{8'h00, 8'h00, chrd_pkg::ST_BAD_LENGTH, 1'b0}));
      dir.push_back(mk_typed(mk_beat(chrd_pkg::ACT_LOAD, 8'h06, 6'd25, 0, 0, 0),
                             '{8'h00, 8'h00, chrd_pkg::ST_BAD_LENGTH, 1'b0}));
      dir.push_back(mk_beat(chrd_pkg::ACT_LOAD, 8'h07, 6'd24, 0, 0, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_CLEAR, 8'hFF, 6'h3F, 8'hFF, 4'hF, 1));
      dir.push_back(mk_beat(chrd_pkg::ACT_LOAD, 8'h41, 6'd1, 0, 0, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_LOAD, 8'hFF, 6'd2, 0, 0, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_LOAD, 8'h00, 6'd3, 0, 0, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_LOAD, 8'h80, 6'd0, 0, 0, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_FINALIZE, 0, 0, 0, 0, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'h00, 4'd8, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'hFF, 4'd0, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'h00, 4'd15, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'h98, 4'd6, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'hB0, 4'd6, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'h80, 4'd2, 1));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'hFF, 4'd8, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'hFF, 4'd8, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'hFF, 4'd8, 0));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'hE0, 4'd3, 1));
      dir.push_back(mk_beat(chrd_pkg::ACT_PAYLOAD, 0, 0, 8'h00, 4'd8, 1));
      foreach (dir[i])
         send_beat(dir[i]);

      for (int ph = 0; ph < 9; ph++) begin
         if (ph >= 7)
            idle_on = 0;
         send_beat(mk_beat(chrd_pkg::ACT_CLEAR, 8'($urandom), 6'($urandom), 8'($urandom),
                           4'($urandom), 1'($urandom)));
         load_table(ph == 2 || ph == 6, ph % 3 == 1);
         send_beat(mk_beat(chrd_pkg::ACT_FINALIZE, 8'($urandom), 6'($urandom), 8'($urandom),
                           4'($urandom), 1'($urandom)));
         nstream = $urandom_range(14, 24);
         for (int k = 0; k < nstream; k++)
            send_beat(rand_payload(k == nstream - 1 || $urandom_range(0, 15) == 0));
         streams++;
         if (ph == 4) begin
            start <= 0;
            while (pending_q.size() != 0)
               @(posedge clock);
            repeat (25) @(posedge clock);
         end
      end

      start <= 0;
      while (pending_q.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d beats over %0d code tables and %0d streams.", beats_sent, tables,
               streams);
      $display("Checked %0d results, %0d of them with error status.", results_seen,
               error_results);
      if (mismatches == 0 && pending_q.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/chrd_pkg.sv
rtl/chrd_match.sv
rtl/canonical_huffman_rle_decoder.sv
tb/sv/tb.sv
